FILE: rtl/core/clib_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clib_pkg
// Shared constants and types for the console line-input buffer: character
// codes, request and result kinds, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package clib_pkg;

  localparam int DEF_BUFFER_DEPTH = 128;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic REQ_RX   = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic decide;
    logic advance;
  } clib_cmd_t;

  typedef struct packed {
    logic emit;
    logic last;
  } clib_stat_t;

endpackage

FILE: rtl/core/clib_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clib_ctrl
// Sequencer for the line-input buffer: takes one word, runs the store lookup
// and the decision step, then hands out any result words one at a time.
// ----------------------------------------------------------------------------
module clib_ctrl
  import clib_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  clib_stat_t stat,
  output clib_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        state_nxt = stat.emit ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_tready && stat.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready   = (state_r == ST_IDLE);
  assign out_tvalid  = (state_r == ST_EMIT);
  assign cmd.capture = in_tvalid && in_tready;
  assign cmd.lookup  = (state_r == ST_LOOKUP);
  assign cmd.decide  = (state_r == ST_DECIDE);
  assign cmd.advance = out_tvalid && out_tready;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("Input accepted while a result is pending.");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && stat.last) |=> in_tready)
    else $error("Controller did not return to idle after the final word.");

endmodule

FILE: rtl/core/clib_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clib_dpath
// Ring buffer store, pointers, item registers and the result register of
// the line-input buffer.
// ----------------------------------------------------------------------------
module clib_dpath
  import clib_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  clib_cmd_t  cmd,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  input  logic [7:0] room_left,
  output clib_stat_t stat,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       line_ready,
  output logic       end_of_read
);

  localparam int TWO_D = 2 * BUFFER_DEPTH;
  localparam int PTR_W = $clog2(TWO_D);
  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [7:0] mem [BUFFER_DEPTH];

  logic             req_r;
  logic [7:0]       ch_r;
  logic [7:0]       room_r;
  logic [7:0]       mem_q_r;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             line_r, line_nxt;
  logic             eor_r, eor_nxt;
  logic             last_r, last_nxt;
  logic [1:0]       beat_r, beat_nxt;

  logic [PTR_W:0]   fill;
  logic             empty;
  logic             full;
  logic             is_erase;
  logic             emit;
  logic             store_en;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic [PTR_W-1:0] wp_dec;

  function automatic logic [IDX_W-1:0] to_idx(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] t;
    t = (p >= PTR_W'(BUFFER_DEPTH)) ? p - PTR_W'(BUFFER_DEPTH) : p;
    return t[IDX_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(TWO_D - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wp_dec = (wp_r == '0) ? PTR_W'(TWO_D - 1) : wp_r - PTR_W'(1);

  assign fill = (wp_r >= rp_r) ? {1'b0, wp_r} - {1'b0, rp_r}
                               : {1'b0, wp_r} + (PTR_W+1)'(TWO_D) - {1'b0, rp_r};
  assign empty = (fill == '0);
  assign full  = (fill >= (PTR_W+1)'(BUFFER_DEPTH));

  assign is_erase = (req_r == REQ_RX) && ((ch_r == CH_DEL) || (ch_r == CH_BS));
  assign rd_idx   = (req_r == REQ_READ) ? to_idx(rp_r) : to_idx(wp_dec);
  assign wr_idx   = to_idx(wp_r);

  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    kind_nxt = kind_r;
    byte_nxt = byte_r;
    line_nxt = line_r;
    eor_nxt  = eor_r;
    last_nxt = last_r;
    beat_nxt = beat_r;
    emit     = 1'b0;
    store_en = 1'b0;
    if (cmd.decide) begin
      beat_nxt = '0;
      line_nxt = 1'b0;
      eor_nxt  = 1'b0;
      last_nxt = 1'b1;
      if (req_r == REQ_READ) begin
        emit = 1'b1;
        if (empty) begin
          kind_nxt = KIND_EMPTY;
          byte_nxt = '0;
        end else begin
          kind_nxt = KIND_READ;
          byte_nxt = mem_q_r;
          eor_nxt  = (mem_q_r == CH_LF) || (room_r <= 8'd1);
          rp_nxt   = ptr_inc(rp_r);
        end
      end else if (is_erase) begin
        // The erase echo is backspace, space, backspace.
        emit     = !empty && (mem_q_r != CH_LF);
        kind_nxt = KIND_ECHO;
        byte_nxt = CH_BS;
        last_nxt = 1'b0;
        if (emit) wp_nxt = wp_dec;
      end else begin
        emit     = !full;
        store_en = !full;
        kind_nxt = KIND_ECHO;
        byte_nxt = ch_r;
        line_nxt = (ch_r == CH_LF);
        if (!full) wp_nxt = ptr_inc(wp_r);
      end
    end else if (cmd.advance) begin
      beat_nxt = beat_r + 2'd1;
      byte_nxt = (beat_r == 2'd0) ? CH_SP : CH_BS;
      last_nxt = (beat_r == 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= req_type;
      ch_r   <= (rx_byte == CH_CR) ? CH_LF : rx_byte;
      room_r <= room_left;
    end
    if (cmd.lookup) begin
      mem_q_r <= mem[rd_idx];
    end
    if (store_en) begin
      mem[wr_idx] <= ch_r;
    end
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    line_r <= line_nxt;
    eor_r  <= eor_nxt;
    beat_r <= beat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      last_r <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      last_r <= last_nxt;
    end
  end

  assign stat.emit   = emit;
  assign stat.last   = last_r;
  assign out_kind    = kind_r;
  assign out_byte    = byte_r;
  assign line_ready  = line_r;
  assign end_of_read = eor_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= (PTR_W+1)'(BUFFER_DEPTH))
    else $error("Buffer fill level exceeds its depth.");

  a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.decide |=> ($stable(wp_r) && $stable(rp_r)))
    else $error("A pointer moved outside the decision step.");

endmodule

FILE: rtl/core/console_line_input_buffer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_input_buffer_unit
// Console line-input ring buffer with backspace editing, echo and
// one-byte reads.
//
//   Channel  Direction  Payload
//   in_*     slave      tuser: req_type; tdata: rx_byte, room_left
//   out_*    master     tuser: out_kind, line_ready, end_of_read;
//                       tdata: out_byte; tlast: last
//
// An item passes through accept, store lookup and decision, then leaves as zero
// to three result words, one word per cycle while the consumer is ready.
// The lookup step comes from the registered read of the single-port line store,
// and the output register holds one word at a time.
// Reset is synchronous and active low; the line store itself is not cleared.
// Stalls on the output hold the current word and keep in_tready low.
// ----------------------------------------------------------------------------
module console_line_input_buffer_unit
  import clib_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_byte, [15:8] room_left
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [3:0]  out_tuser,  // [1:0] out_kind, [2] line_ready, [3] end_of_read
  output logic        out_tlast
);

  clib_cmd_t  cmd;
  clib_stat_t stat;

  clib_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  clib_dpath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .req_type    (in_tuser),
    .rx_byte     (in_tdata[7:0]),
    .room_left   (in_tdata[15:8]),
    .stat        (stat),
    .out_kind    (out_tuser[1:0]),
    .out_byte    (out_tdata),
    .line_ready  (out_tuser[2]),
    .end_of_read (out_tuser[3])
  );

  assign out_tlast = stat.last;

endmodule
